[rtl/first_fit_heap_allocator_defines.svh]
// Assertion macros shared by the allocator RTL files.
// Plain text macros only; no dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define FFHA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define FFHA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ffha_pkg.sv]
// Package for the first-fit heap allocator: field widths, codes, table entry
// and controller/datapath interface structs. No dependencies.
`default_nettype none

package ffha_pkg;

    // Fixed field widths
    localparam int START_W  = 20;
    localparam int SIZE_W   = 20;
    localparam int ADDR_W   = 21;
    localparam int LIMIT_W  = 21;
    localparam int EXT_W    = ADDR_W + 1;   // headroom for top + header + size
    localparam int STATUS_W = 3;

    // Stream and register port widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Largest heap, and reset value of the limit register
    localparam logic [LIMIT_W-1:0] HEAP_CAP = LIMIT_W'(1048576);

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BLOCKS   = 16;
    localparam int DEF_HEADER_BYTES = 16;

    // Operation selector
    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_NULL    = 3'd1,
        STS_LIMIT   = 3'd2,
        STS_FULL    = 3'd3,
        STS_UNKNOWN = 3'd4
    } status_t;

    // Register index of the limit register
    localparam logic REG_HEAP_LIMIT = 1'b0;

    // One block table entry
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               free;
    } entry_t;

    // Controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic respond;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_null;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

[rtl/ffha_ctrl.sv]
// Controller state machine of the allocator: accept, scan, update, respond.
// Depends on ffha_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.req_null || sts.scan_hit || sts.scan_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_RESP: begin
                cmd.respond = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `FFHA_ASSERT_IMP(a_resp_slot, aclk, aresetn, cmd.respond, sts.out_free, "result loaded over a waiting word")
    `FFHA_ASSERT_NXT(a_load_scan, aclk, aresetn, cmd.load, state_reg == ST_SCAN, "accepted word not scanned")
    `FFHA_ASSERT_IMP(a_upd_after_scan, aclk, aresetn, state_reg == ST_UPDATE, $past(state_reg) == ST_SCAN, "update without scan")

endmodule

`default_nettype wire

[rtl/ffha_datapath.sv]
// Datapath of the allocator: block table memory, scan pipeline, heap state,
// limit register with its APB port, and the result register.
// Depends on ffha_pkg and the assertion macro header.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request word
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    // result word
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser,
    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready,
    // controller
    input  wire ctl_cmd_t             cmd,
    output ctl_sts_t                  sts
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [EXT_W-1:0] HDR_EXT = EXT_W'(HEADER_BYTES);

    // Block table
    entry_t mem [MAX_BLOCKS];

    // Limit register
    logic [LIMIT_W-1:0] limit_reg;

    // Request
    func_t              req_func_reg;
    logic [SIZE_W-1:0]  req_size_reg;
    logic [ADDR_W-1:0]  req_addr_reg;

    // Scan pipeline
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   scan_idx_next;
    logic               chk_valid_reg;
    logic               chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg;
    entry_t             rd_data_reg;
    logic               exhausted;
    logic               match;
    logic               hit;

    // Captured hit
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [START_W-1:0] hit_start_reg;
    logic [SIZE_W-1:0]  hit_size_reg;

    // Heap state
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ADDR_W-1:0]  top_reg;
    logic [ADDR_W-1:0]  top_next;

    // Pending result
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [ADDR_W-1:0]  res_addr_next;
    status_t            res_status_reg;
    status_t            res_status_next;
    logic               res_reused_reg;
    logic               res_reused_next;

    // Output register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [ADDR_W-1:0]  m_addr_reg;
    status_t            m_status_reg;
    logic               m_reused_reg;

    // Table write port
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_data;

    // Update arithmetic
    logic [EXT_W-1:0]   lim_ext;
    logic [EXT_W-1:0]   new_end;
    logic [EXT_W-1:0]   hit_end;

    // APB: one register, written on the access cycle
    assign pready = 1'b1;

    always_comb begin
        if (paddr[2] == REG_HEAP_LIMIT) begin
            prdata = APB_DW'(limit_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= HEAP_CAP;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_LIMIT) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_func_reg <= func_t'(s_tuser[0]);
            req_size_reg <= s_tdata[SIZE_W-1:0];
            req_addr_reg <= s_tdata[SIZE_W +: ADDR_W];
        end
    end

    assign sts.req_null = (req_func_reg == FUNC_ALLOC) ? (req_size_reg == '0)
                                                       : (req_addr_reg == '0);

    // Scan: one table read issued per cycle, checked in the cycle after
    assign exhausted = (scan_idx_reg >= count_reg);

    always_comb begin
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        if (cmd.load) begin
            scan_idx_next  = '0;
            chk_valid_next = 1'b0;
        end else if (cmd.scan) begin
            chk_valid_next = !exhausted;
            if (!exhausted) scan_idx_next = scan_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        if (cmd.scan && !exhausted) chk_idx_reg <= scan_idx_reg[IDX_W-1:0];
    end

    // First-fit test for allocate, address match for release
    always_comb begin
        if (req_func_reg == FUNC_ALLOC) begin
            match = rd_data_reg.free && (rd_data_reg.size >= req_size_reg);
        end else begin
            match = (EXT_W'(rd_data_reg.start) + HDR_EXT) == EXT_W'(req_addr_reg);
        end
    end

    assign hit           = chk_valid_reg && match;
    assign sts.scan_hit  = hit;
    assign sts.scan_done = !chk_valid_reg && exhausted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
        end else if (cmd.scan && hit) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan && hit) begin
            hit_idx_reg   <= chk_idx_reg;
            hit_start_reg <= rd_data_reg.start;
            hit_size_reg  <= rd_data_reg.size;
        end
    end

    // Table and heap update, result formed alongside
    assign lim_ext = (limit_reg > HEAP_CAP) ? EXT_W'(HEAP_CAP) : EXT_W'(limit_reg);
    assign new_end = EXT_W'(top_reg) + HDR_EXT + EXT_W'(req_size_reg);
    assign hit_end = EXT_W'(hit_start_reg) + HDR_EXT + EXT_W'(hit_size_reg);

    always_comb begin
        count_next      = count_reg;
        top_next        = top_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_reused_next = res_reused_reg;
        wr_en           = 1'b0;
        wr_idx          = hit_idx_reg;
        wr_data         = '{start: hit_start_reg, size: hit_size_reg, free: 1'b0};
        if (cmd.update) begin
            res_addr_next   = '0;
            res_reused_next = 1'b0;
            res_status_next = STS_OK;
            if (sts.req_null) begin
                res_status_next = STS_NULL;
            end else if (req_func_reg == FUNC_ALLOC) begin
                priority if (found_reg) begin
                    // reuse a free block
                    wr_en           = 1'b1;
                    res_addr_next   = ADDR_W'(EXT_W'(hit_start_reg) + HDR_EXT);
                    res_reused_next = 1'b1;
                end else if (count_reg >= CNT_MAX) begin
                    res_status_next = STS_FULL;
                end else if (new_end > lim_ext) begin
                    res_status_next = STS_LIMIT;
                end else begin
                    // append at the heap top
                    wr_en         = 1'b1;
                    wr_idx        = count_reg[IDX_W-1:0];
                    wr_data       = '{start: top_reg[START_W-1:0], size: req_size_reg,
                                      free: 1'b0};
                    count_next    = count_reg + CNT_W'(1);
                    top_next      = new_end[ADDR_W-1:0];
                    res_addr_next = ADDR_W'(EXT_W'(top_reg) + HDR_EXT);
                end
            end else begin
                priority if (!found_reg) begin
                    res_status_next = STS_UNKNOWN;
                end else if (hit_end == EXT_W'(top_reg)) begin
                    // top block: drop it and everything after it
                    top_next   = ADDR_W'(hit_start_reg);
                    count_next = CNT_W'(hit_idx_reg);
                end else begin
                    wr_en        = 1'b1;
                    wr_data.free = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            top_reg   <= '0;
        end else begin
            count_reg <= count_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_reused_reg <= res_reused_next;
    end

    // Output register: holds a word until taken
    assign sts.out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.respond) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.respond) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
            m_reused_reg <= res_reused_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_addr_reg);
    assign m_tuser  = {m_reused_reg, m_status_reg};

    `FFHA_ASSERT_IMP(a_empty_top, aclk, aresetn, count_reg == '0, top_reg == '0, "empty table with nonzero top")
    `FFHA_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_MAX, "entry count beyond table depth")
    `FFHA_ASSERT_IMP(a_hit_in_table, aclk, aresetn, found_reg && cmd.update, CNT_W'(hit_idx_reg) < count_reg, "hit index outside table")

endmodule

`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator. Each request word is accepted, then the block
// table is walked one entry per cycle up to the first matching entry or to
// the end of the entries in use (a null request or an empty table ends the
// walk with no entry checked), then the table is updated and the result
// register is loaded, which waits while an earlier result still waits on
// m_tready. The walk is set by the single read port of the block table
// memory. A new request is taken while the previous result waits in the
// output register. s_tuser selects allocate (0) or release (1).
// Top level: instantiates ffha_ctrl and ffha_datapath; depends on ffha_pkg.
`default_nettype none

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [19:0] req_size, [40:20] block_addr
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // [0] func
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [20:0] result_addr
    output logic [M_TUSER_W-1:0]      m_tuser,   // [2:0] status, [3] reused
    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffha_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire
